// ----- rtl/affix_splitting_word_tokenizer_unit_assert.svh -----
// assertion macros for the tokenizer checker
// expects signals named clk and arst_n in the scope of use
`ifndef AFFIX_SPLITTING_WORD_TOKENIZER_UNIT_ASSERT_SVH
`define AFFIX_SPLITTING_WORD_TOKENIZER_UNIT_ASSERT_SVH
// same-cycle implication
`define ASWT_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASWT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/aswt_pkg.sv -----
// shared types, constants and affix tables of the tokenizer
// no dependencies
package aswt_pkg;
	localparam int MAX_WORD     = 32;
	localparam int ADDR_W       = $clog2(MAX_WORD);
	localparam int LEN_W        = $clog2(MAX_WORD + 1);
	localparam int PREFIX_COUNT = 24;
	localparam int SUFFIX_COUNT = 34;
	localparam int MAX_RESULTS  = 37;
	localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
	localparam int SEP_COUNT    = 6;
	localparam int AFFIX_CHARS  = 5;
	localparam int CFG_IDX_W    = 3;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CASE_OFS = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEP_0, REG_SEP_1, REG_SEP_2, REG_SEP_3, REG_SEP_4, REG_SEP_5, REG_SPLIT_MIN
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]               len;
		logic [8*AFFIX_CHARS-1:0] txt;  // right aligned, last char in low byte
	} affix_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_sep;
		logic       eot;
	} cmd_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       cvalid;
		logic       tend;
		logic       trunc;
	} res_t;

	localparam affix_t PREFIX_ROM [PREFIX_COUNT] = '{
		'{3'd2, 40'("un")},    '{3'd2, 40'("re")},    '{3'd2, 40'("in")},
		'{3'd2, 40'("im")},    '{3'd2, 40'("ir")},    '{3'd2, 40'("il")},
		'{3'd3, 40'("dis")},   '{3'd2, 40'("en")},    '{3'd2, 40'("em")},
		'{3'd3, 40'("non")},   '{3'd4, 40'("over")},  '{3'd3, 40'("mis")},
		'{3'd3, 40'("sub")},   '{3'd3, 40'("pre")},   '{3'd5, 40'("inter")},
		'{3'd4, 40'("fore")},  '{3'd2, 40'("de")},    '{3'd5, 40'("trans")},
		'{3'd5, 40'("super")}, '{3'd4, 40'("semi")},  '{3'd4, 40'("anti")},
		'{3'd3, 40'("mid")},   '{3'd5, 40'("under")}, '{3'd4, 40'("over")}
	};

	localparam affix_t SUFFIX_ROM [SUFFIX_COUNT] = '{
		'{3'd1, 40'("s")},     '{3'd2, 40'("es")},    '{3'd2, 40'("ed")},
		'{3'd3, 40'("ing")},   '{3'd2, 40'("ly")},    '{3'd2, 40'("er")},
		'{3'd2, 40'("or")},    '{3'd3, 40'("ion")},   '{3'd4, 40'("tion")},
		'{3'd5, 40'("ation")}, '{3'd5, 40'("ition")}, '{3'd4, 40'("ible")},
		'{3'd4, 40'("able")},  '{3'd2, 40'("al")},    '{3'd3, 40'("ial")},
		'{3'd1, 40'("y")},     '{3'd4, 40'("ness")},  '{3'd3, 40'("ity")},
		'{3'd4, 40'("ment")},  '{3'd2, 40'("ic")},    '{3'd3, 40'("ous")},
		'{3'd4, 40'("eous")},  '{3'd4, 40'("ious")},  '{3'd2, 40'("en")},
		'{3'd3, 40'("ify")},   '{3'd3, 40'("ise")},   '{3'd3, 40'("ize")},
		'{3'd4, 40'("ward")},  '{3'd4, 40'("wise")},  '{3'd4, 40'("hood")},
		'{3'd4, 40'("ship")},  '{3'd3, 40'("dom")},   '{3'd3, 40'("ful")},
		'{3'd4, 40'("less")}
	};

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
	endfunction
endpackage

// ----- rtl/aswt_if.sv -----
// channel interfaces of the tokenizer: text input, result output, register writes
// depends on aswt_pkg
interface aswt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_text;
	modport source (output valid, in_char, end_of_text, input ready);
	modport sink (input valid, in_char, end_of_text, output ready);
endinterface

interface aswt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       token_end;
	logic       word_truncated;
	logic       last;
	modport source (output valid, out_char, char_valid, token_end, word_truncated, last,
		input ready);
	modport sink (input valid, out_char, char_valid, token_end, word_truncated, last,
		output ready);
endinterface

interface aswt_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [aswt_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/affix_splitting_word_tokenizer_unit.sv -----
// Affix-splitting word tokenizer, top level.
// Channels: in_ch takes one text byte per transaction with an end_of_text flag;
// res gives one result per transaction: a token character or an empty-token
// mark, token_end on the final item of each piece, word_truncated for words
// longer than 32 bytes, last on the final result caused by one input byte;
// cfg writes separator bytes (index 0..5) and the split length (index 6).
// A byte goes through a two-entry queue into the emitter, which takes one
// queued byte at a time. A byte that emits nothing passes through the idle,
// start, append, end-of-text and finish states. A word adds the match,
// middle check and closing states, a step per hash or affix character and
// a buffer read then a send per middle character, since the word buffer has
// one registered read port. A generated result is first held back in a
// pending register to learn whether it is the last, then moves to the output
// register. A stalled receiver halts the emitter, then the queue, then in_ch.
// Reset clears the word, the queue and the output and restores the default
// separators and split length; no clearing pass is needed.
// depends on aswt_pkg, aswt_if and the three submodules
module affix_splitting_word_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	aswt_in_if.sink     in_ch,
	aswt_out_if.source  res,
	aswt_cfg_if.sink    cfg
);
	import aswt_pkg::*;

	cmd_t             f_cmd, q_cmd;
	logic             f_valid, f_ready, q_valid, q_ready;
	logic [LEN_W-1:0] split_min;

	aswt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg),
		.cmd       (f_cmd),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.split_min (split_min)
	);

	aswt_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (f_cmd),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_cmd   (q_cmd),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	aswt_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.split_min (split_min),
		.res       (res)
	);
endmodule

// ----- rtl/aswt_front.sv -----
// front end: register file and byte classification against separators
// depends on aswt_pkg and aswt_if
module aswt_front (
	input  logic                           clk,
	input  logic                           arst_n,
	aswt_in_if.sink                        in_ch,
	aswt_cfg_if.sink                       cfg,
	output aswt_pkg::cmd_t                 cmd,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output logic [aswt_pkg::LEN_W-1:0]     split_min
);
	import aswt_pkg::*;

	logic [7:0]       sep_q [SEP_COUNT];
	logic [LEN_W-1:0] split_q;
	logic             hit;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q[0] <= 8'h21;
			sep_q[1] <= 8'h2e;
			sep_q[2] <= 8'h5f;
			sep_q[3] <= 8'h2c;
			sep_q[4] <= 8'h26;
			sep_q[5] <= 8'h40;
			split_q  <= LEN_W'(4);
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_SEP_0:     sep_q[0] <= cfg.data;
				REG_SEP_1:     sep_q[1] <= cfg.data;
				REG_SEP_2:     sep_q[2] <= cfg.data;
				REG_SEP_3:     sep_q[3] <= cfg.data;
				REG_SEP_4:     sep_q[4] <= cfg.data;
				REG_SEP_5:     sep_q[5] <= cfg.data;
				REG_SPLIT_MIN: split_q  <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < SEP_COUNT; i++)
			if (sep_q[i] == in_ch.in_char) hit = 1'b1;
	end

	assign cmd.ch      = in_ch.in_char;
	assign cmd.is_sep  = hit;
	assign cmd.eot     = in_ch.end_of_text;
	assign cmd_valid   = in_ch.valid;
	assign in_ch.ready = cmd_ready;
	assign split_min   = split_q;
endmodule

// ----- rtl/aswt_cmdq.sv -----
// two-entry queue of classified bytes between front and emitter
// depends on aswt_pkg
module aswt_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  aswt_pkg::cmd_t wr_cmd,
	input  logic           wr_valid,
	output logic           wr_ready,
	output aswt_pkg::cmd_t rd_cmd,
	output logic           rd_valid,
	input  logic           rd_ready
);
	import aswt_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_cmd   = ent_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= wr_cmd;
	end
endmodule

// ----- rtl/aswt_emit.sv -----
// back end: word buffer, affix match and per-character result sequencer
// depends on aswt_pkg and aswt_if
module aswt_emit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  aswt_pkg::cmd_t             cmd,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  logic [aswt_pkg::LEN_W-1:0] split_min,
	aswt_out_if.source                 res
);
	import aswt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_APPEND, S_EOT, S_FIN,
		E_MATCH, E_PRE, E_MIDCHK, E_MIDRD, E_MIDWR, E_SUF, E_DONE
	} state_t;

	state_t                   state_q, ret_q;
	cmd_t                     cmd_q;
	logic [LEN_W-1:0]         len_q;
	logic                     ovf_q;
	logic [7:0]               mem [MAX_WORD];
	logic [7:0]               rdata_q;
	logic [8*AFFIX_CHARS-1:0] first_q;  // byte k = word char k
	logic [8*AFFIX_CHARS-1:0] last_q;   // byte j = j-th char from the end
	affix_t                   pre_q, suf_q;
	logic                     has_suf_q;
	logic [ADDR_W-1:0]        mid_start_q;
	logic [LEN_W-1:0]         mid_len_q;
	logic                     mid_tok_q;
	logic [LEN_W-1:0]         k_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     p_valid_q;
	res_t                     p_q;
	logic                     o_valid_q;
	res_t                     o_q;
	logic                     o_last_q;

	// match results
	affix_t           pre_sel, suf_sel;
	logic             pre_hit, suf_hit, do_split, split, overlap;
	logic [LEN_W-1:0] pl, sl, mid_len;
	// generated result
	logic             gen_valid, gen_end, take, drop, mv_ok, o_load;
	res_t             gen;
	logic [ADDR_W-1:0] rd_addr;

	function automatic logic pre_ok(input affix_t a, input logic [8*AFFIX_CHARS-1:0] f,
		input logic [LEN_W-1:0] wl);
		logic ok;
		ok = (a.len != 3'd0) && (LEN_W'(a.len) <= wl);
		for (int k = 0; k < AFFIX_CHARS; k++)
			if (k < int'(a.len))
				if (to_lower(f[8*k +: 8]) != a.txt[8*(int'(a.len)-1-k) +: 8]) ok = 1'b0;
		return ok;
	endfunction

	function automatic logic suf_ok(input affix_t a, input logic [8*AFFIX_CHARS-1:0] t,
		input logic [LEN_W-1:0] wl);
		logic ok;
		ok = (a.len != 3'd0) && (LEN_W'(a.len) <= wl);
		for (int j = 0; j < AFFIX_CHARS; j++)
			if (j < int'(a.len))
				if (to_lower(t[8*j +: 8]) != a.txt[8*j +: 8]) ok = 1'b0;
		return ok;
	endfunction

	always_comb begin
		pre_sel  = '0;
		suf_sel  = '0;
		pre_hit  = 1'b0;
		suf_hit  = 1'b0;
		do_split = len_q > split_min;
		// reverse scan so the earliest table entry wins
		for (int i = PREFIX_COUNT - 1; i >= 0; i--)
			if (do_split && pre_ok(PREFIX_ROM[i], first_q, len_q)) begin
				pre_sel = PREFIX_ROM[i];
				pre_hit = 1'b1;
			end
		for (int i = SUFFIX_COUNT - 1; i >= 0; i--)
			if (do_split && suf_ok(SUFFIX_ROM[i], last_q, len_q)) begin
				suf_sel = SUFFIX_ROM[i];
				suf_hit = 1'b1;
			end
		pl      = pre_hit ? LEN_W'(pre_sel.len) : '0;
		sl      = suf_hit ? LEN_W'(suf_sel.len) : '0;
		split   = pre_hit || suf_hit;
		overlap = (pl + sl) > len_q;
		if (!split) mid_len = len_q;
		else if (overlap) mid_len = len_q - pl;
		else mid_len = len_q - pl - sl;
	end

	assign rd_addr = mid_start_q + k_q[ADDR_W-1:0];

	always_comb begin
		gen_valid  = 1'b0;
		gen_end    = 1'b0;
		gen.ch     = CH_HASH;
		gen.cvalid = 1'b1;
		gen.trunc  = ovf_q;
		case (state_q)
			E_PRE: begin
				gen_valid = 1'b1;
				gen_end   = (k_q == LEN_W'(pre_q.len) + LEN_W'(1));
				if (k_q >= LEN_W'(2))
					gen.ch = pre_q.txt[8*(int'(pre_q.len) + 1 - int'(k_q)) +: 8];
			end
			E_MIDCHK: begin
				gen_valid  = (mid_len_q == '0) && mid_tok_q;
				gen_end    = 1'b1;
				gen.cvalid = 1'b0;
				gen.ch     = 8'h00;
			end
			E_MIDWR: begin
				gen_valid = 1'b1;
				gen_end   = (k_q == mid_len_q - LEN_W'(1));
				gen.ch    = rdata_q;
			end
			E_SUF: begin
				gen_valid = 1'b1;
				gen_end   = (k_q == LEN_W'(suf_q.len) + LEN_W'(1));
				if (k_q < LEN_W'(suf_q.len))
					gen.ch = suf_q.txt[8*(int'(suf_q.len) - 1 - int'(k_q)) +: 8];
			end
			default: ;
		endcase
		gen.tend = gen_end;
	end

	assign mv_ok     = !o_valid_q || res.ready;
	assign drop      = (cnt_q >= CNT_W'(MAX_RESULTS));
	assign take      = gen_valid && (drop || !p_valid_q || mv_ok);
	assign cmd_ready = (state_q == S_IDLE);
	assign o_load    = (take && !drop && p_valid_q) ||
		(state_q == S_FIN && p_valid_q && mv_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			len_q     <= '0;
			ovf_q     <= 1'b0;
			k_q       <= '0;
			cnt_q     <= '0;
			p_valid_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (o_load) o_valid_q <= 1'b1;
			else if (res.ready) o_valid_q <= 1'b0;
			// pending result moves on once a newer one arrives
			if (take && !drop) begin
				if (p_valid_q) begin
					o_q      <= p_q;
					o_last_q <= 1'b0;
				end
				p_q       <= gen;
				p_valid_q <= 1'b1;
				cnt_q     <= cnt_q + CNT_W'(1);
			end
			case (state_q)
				S_IDLE: if (cmd_valid) begin
					cmd_q   <= cmd;
					state_q <= S_START;
				end
				S_START: begin
					if (cmd_q.is_sep) begin
						ret_q   <= S_APPEND;
						state_q <= E_MATCH;
					end else state_q <= S_APPEND;
				end
				S_APPEND: begin
					state_q <= S_EOT;
					if (cmd_q.ch == CH_SPACE) begin
						if (len_q != '0) begin
							ret_q   <= S_EOT;
							state_q <= E_MATCH;
						end
					end else if (len_q < LEN_W'(MAX_WORD)) begin
						if (len_q < LEN_W'(AFFIX_CHARS))
							first_q[8*len_q[2:0] +: 8] <= cmd_q.ch;
						last_q <= {last_q[8*(AFFIX_CHARS-1)-1:0], cmd_q.ch};
						len_q  <= len_q + LEN_W'(1);
					end else ovf_q <= 1'b1;
				end
				S_EOT: begin
					if (cmd_q.eot && len_q != '0) begin
						ret_q   <= S_FIN;
						state_q <= E_MATCH;
					end else state_q <= S_FIN;
				end
				S_FIN: begin
					if (!p_valid_q) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else if (mv_ok) begin
						o_q       <= p_q;
						o_last_q  <= 1'b1;
						p_valid_q <= 1'b0;
						cnt_q     <= '0;
						state_q   <= S_IDLE;
					end
				end
				E_MATCH: begin
					pre_q       <= pre_sel;
					suf_q       <= suf_sel;
					has_suf_q   <= suf_hit;
					mid_start_q <= pl[ADDR_W-1:0];
					mid_len_q   <= mid_len;
					mid_tok_q   <= (mid_len == '0) && (!split || overlap);
					k_q         <= '0;
					state_q     <= pre_hit ? E_PRE : E_MIDCHK;
				end
				E_PRE: if (take) begin
					if (gen_end) begin
						k_q     <= '0;
						state_q <= E_MIDCHK;
					end else k_q <= k_q + LEN_W'(1);
				end
				E_MIDCHK: begin
					k_q <= '0;
					if (mid_len_q != '0) state_q <= E_MIDRD;
					else if (!mid_tok_q || take) state_q <= has_suf_q ? E_SUF : E_DONE;
				end
				E_MIDRD: state_q <= E_MIDWR;
				E_MIDWR: if (take) begin
					if (gen_end) begin
						k_q     <= '0;
						state_q <= has_suf_q ? E_SUF : E_DONE;
					end else begin
						k_q     <= k_q + LEN_W'(1);
						state_q <= E_MIDRD;
					end
				end
				E_SUF: if (take) begin
					if (gen_end) begin
						k_q     <= '0;
						state_q <= E_DONE;
					end else k_q <= k_q + LEN_W'(1);
				end
				E_DONE: begin
					len_q   <= '0;
					ovf_q   <= 1'b0;
					state_q <= ret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_APPEND && cmd_q.ch != CH_SPACE && len_q < LEN_W'(MAX_WORD))
			mem[len_q[ADDR_W-1:0]] <= cmd_q.ch;
		if (state_q == E_MIDRD) rdata_q <= mem[rd_addr];
	end

	assign res.valid          = o_valid_q;
	assign res.out_char       = o_q.ch;
	assign res.char_valid     = o_q.cvalid;
	assign res.token_end      = o_q.tend;
	assign res.word_truncated = o_q.trunc;
	assign res.last           = o_last_q;
endmodule

// ----- rtl/aswt_checker.sv -----
// port-level checks on the result channel of the tokenizer
// depends on the assertion macro header; bound to the top level
`include "affix_splitting_word_tokenizer_unit_assert.svh"
module aswt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] out_char,
	input logic       char_valid,
	input logic       token_end,
	input logic       word_truncated,
	input logic       last_flag
);
	logic [11:0] payload;
	assign payload = {out_char, char_valid, token_end, word_truncated, last_flag};

	`ASWT_ASSERT_NEXT(a_valid_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`ASWT_ASSERT_NEXT(a_data_hold, res_valid && !res_ready, $stable(payload), "result changed while stalled")
	`ASWT_ASSERT(a_empty_zero, res_valid && !char_valid, out_char == 8'h00, "empty token carries a char")
	`ASWT_ASSERT(a_empty_end, res_valid && !char_valid, token_end, "empty token without token end")
endmodule

bind affix_splitting_word_tokenizer_unit aswt_checker u_aswt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.out_char       (res.out_char),
	.char_valid     (res.char_valid),
	.token_end      (res.token_end),
	.word_truncated (res.word_truncated),
	.last_flag      (res.last)
);

// ----- dv/tb_affix_splitting_word_tokenizer_unit.sv -----
// testbench of the affix-splitting word tokenizer: directed rows, then phases of
// random words under several separator and split-length settings, checked by a predictor
// depends on aswt_pkg, aswt_if and affix_splitting_word_tokenizer_unit
module tb_affix_splitting_word_tokenizer_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import aswt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int LONG_HOLD      = 300;

	typedef struct {
		logic [7:0] ch;
		logic       cv;
		logic       te;
		logic       tr;
		logic       last;
	} tok_t;

	typedef struct {
		logic [7:0] ch;
		bit         eot;
		bit         known_empty;  // a separator on an empty word: one empty token
	} row_t;

	logic clk;
	logic arst_n;
	int   fail_cnt;
	int   idle_cycles;
	int   result_cnt;

	aswt_in_if  in_ch ();
	aswt_out_if res ();
	aswt_cfg_if cfg ();

	affix_splitting_word_tokenizer_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.res    (res),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predicted tokenizer state
	tok_t       token_q [$];
	logic [7:0] sep_tab [SEP_COUNT];
	logic [5:0] split_len;
	logic [7:0] word_buf [MAX_WORD];
	int         word_len;
	bit         word_ovf;
	logic [7:0] text_q [$];

	function automatic logic [7:0] lower_ch(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] affix_char(affix_t a, int k);
		return a.txt[8*(a.len-1-k) +: 8];
	endfunction

	function automatic void emit_piece(logic [7:0] s [$], bit hash_before, bit hash_after);
		logic [7:0] seq [$];
		seq = s;
		if (hash_before) seq = {CH_HASH, CH_HASH, seq};
		if (hash_after) seq = {seq, CH_HASH, CH_HASH};
		if (seq.size() == 0) begin
			token_q.insert(token_q.size(), '{8'd0, 1'b0, 1'b1, word_ovf, 1'b0});
			return;
		end
		foreach (seq[i])
			token_q.insert(token_q.size(),
				'{seq[i], 1'b1, i == seq.size() - 1, word_ovf, 1'b0});
	endfunction

	function automatic void emit_word();
		int         pre_i, suf_i, pre_l, suf_l, mid, k;
		logic [7:0] low [MAX_WORD];
		logic [7:0] piece [$];
		pre_i = -1;
		suf_i = -1;
		pre_l = 0;
		suf_l = 0;
		if (word_len > split_len) begin
			for (int i = 0; i < word_len; i++) low[i] = lower_ch(word_buf[i]);
			for (int i = 0; i < PREFIX_COUNT && pre_i < 0; i++) begin
				if (PREFIX_ROM[i].len == 0 || PREFIX_ROM[i].len > word_len) continue;
				for (k = 0; k < PREFIX_ROM[i].len && low[k] == affix_char(PREFIX_ROM[i], k); k++);
				if (k == PREFIX_ROM[i].len) begin
					pre_i = i;
					pre_l = k;
				end
			end
			for (int i = 0; i < SUFFIX_COUNT && suf_i < 0; i++) begin
				if (SUFFIX_ROM[i].len == 0 || SUFFIX_ROM[i].len > word_len) continue;
				for (k = 0; k < SUFFIX_ROM[i].len &&
					low[word_len-SUFFIX_ROM[i].len+k] == affix_char(SUFFIX_ROM[i], k); k++);
				if (k == SUFFIX_ROM[i].len) begin
					suf_i = i;
					suf_l = k;
				end
			end
		end
		if (pre_i < 0 && suf_i < 0) begin
			for (int i = 0; i < word_len; i++) piece.insert(piece.size(), word_buf[i]);
			emit_piece(piece, 0, 0);
		end else begin
			if (pre_i >= 0) begin
				for (int i = 0; i < pre_l; i++)
					piece.insert(piece.size(), affix_char(PREFIX_ROM[pre_i], i));
				emit_piece(piece, 1, 0);
			end
			mid = word_len - pre_l - suf_l;
			// overlapping affixes: everything after the prefix forms the middle
			if (mid != 0) begin
				piece.delete();
				for (int i = pre_l; i < (mid < 0 ? word_len : pre_l + mid); i++)
					piece.insert(piece.size(), word_buf[i]);
				emit_piece(piece, 0, 0);
			end
			if (suf_i >= 0) begin
				piece.delete();
				for (int i = 0; i < suf_l; i++)
					piece.insert(piece.size(), affix_char(SUFFIX_ROM[suf_i], i));
				emit_piece(piece, 0, 1);
			end
		end
		word_len = 0;
		word_ovf = 0;
	endfunction

	function automatic void tokenize_byte(logic [7:0] c, bit eot);
		int start;
		bit is_sep;
		start = token_q.size();
		is_sep = 0;
		foreach (sep_tab[i]) if (sep_tab[i] == c) is_sep = 1;
		if (is_sep) emit_word();
		if (c == CH_SPACE) begin
			if (word_len > 0) emit_word();
		end else if (word_len < MAX_WORD) begin
			word_buf[word_len] = c;
			word_len++;
		end else begin
			word_ovf = 1;
		end
		if (eot && word_len > 0) emit_word();
		if (token_q.size() > start) token_q[token_q.size()-1].last = 1'b1;
	endfunction

	task automatic send_byte(logic [7:0] c, bit eot, bit known_empty);
		int gap, n0;
		gap = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_char <= c;
		in_ch.end_of_text <= eot;
		do @(posedge clk); while (!in_ch.ready);
		n0 = token_q.size();
		tokenize_byte(c, eot);
		if (known_empty) begin
			while (token_q.size() > n0) void'(token_q.pop_back());
			token_q.insert(token_q.size(), '{8'd0, 1'b0, 1'b1, 1'b0, 1'b1});
		end
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
		// bytes that emit nothing may still be in flight
		repeat (40) @(posedge clk);
	endtask

	// leaves valid high; the caller drops it after the last write
	task automatic write_reg(cfg_reg_t idx, logic [7:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_SPLIT_MIN) split_len = value[5:0];
		else sep_tab[idx] = value;
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'(97 + $urandom_range(0, 25));
		return ($urandom_range(0, 9) < 3) ? c - 8'd32 : c;
	endfunction

	// builds one word in text_q plus a space, a separator or no terminator; returns the eot position flag
	function automatic bit make_word();
		int kind, term;
		affix_t a;
		text_q.delete();
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			if ($urandom_range(0, 3) != 0) begin
				a = PREFIX_ROM[$urandom_range(0, PREFIX_COUNT-1)];
				for (int i = 0; i < a.len; i++)
					text_q.insert(text_q.size(), $urandom_range(0, 3) == 0 ?
						affix_char(a, i) - 8'd32 : affix_char(a, i));
			end
			repeat ($urandom_range(0, 6)) text_q.insert(text_q.size(), rand_letter());
			if ($urandom_range(0, 3) != 0) begin
				a = SUFFIX_ROM[$urandom_range(0, SUFFIX_COUNT-1)];
				for (int i = 0; i < a.len; i++) text_q.insert(text_q.size(), affix_char(a, i));
			end
		end else if (kind == 7) begin
			repeat ($urandom_range(28, 40)) text_q.insert(text_q.size(), rand_letter());
		end else begin
			repeat ($urandom_range(1, 6))
				text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
		end
		term = $urandom_range(0, 9);
		if (term < 6) text_q.insert(text_q.size(), CH_SPACE);
		else if (term < 9)
			text_q.insert(text_q.size(), sep_tab[$urandom_range(0, SEP_COUNT-1)]);
		return term >= 8;
	endfunction

	row_t intro_rows [21] = '{
		'{8'h21, 0, 1},
		'{"U", 0, 0}, '{"n", 0, 0}, '{"d", 0, 0}, '{"o", 0, 0},
		'{"i", 0, 0}, '{"n", 0, 0}, '{"g", 0, 0}, '{8'h20, 0, 0},
		'{"t", 0, 0}, '{"r", 0, 0}, '{"a", 0, 0}, '{"n", 0, 0},
		'{"s", 0, 0}, '{8'h21, 0, 0}, '{8'h20, 0, 0},
		'{8'hff, 0, 0}, '{8'h00, 0, 0}, '{",", 1, 0},
		'{8'h20, 0, 0}, '{"a", 1, 0}
	};

	initial begin
		logic [7:0] seps [SEP_COUNT];
		logic [5:0] split_tab [5];
		int         sent;
		bit         eot_end;
		split_tab = '{6'd4, 6'd0, 6'd32, 6'd5, 6'd1};
		fail_cnt = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.in_char <= 8'd0;
		in_ch.end_of_text <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_SEP_0;
		cfg.data <= 8'd0;
		sep_tab = '{"!", ".", "_", ",", "&", "@"};
		split_len = 6'd4;
		word_len = 0;
		word_ovf = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (intro_rows[i]) send_byte(intro_rows[i].ch, intro_rows[i].eot,
			intro_rows[i].known_empty);

		for (int phase = 0; phase < 5; phase++) begin
			wait_idle();
			case (phase)
				0: seps = '{"!", ".", "_", ",", "&", "@"};
				1: seps = '{8'h00, 8'hff, 8'h20, "a", "#", "-"};
				default: foreach (seps[i]) seps[i] = (i < 3) ? 8'($urandom_range(0, 255)) :
					8'($urandom_range(33, 126));
			endcase
			for (int i = 0; i < SEP_COUNT; i++) write_reg(cfg_reg_t'(i), seps[i]);
			write_reg(REG_SPLIT_MIN, {2'b00, split_tab[phase]});
			cfg.valid <= 1'b0;
			sent = 0;
			while (sent < 44) begin
				eot_end = make_word();
				foreach (text_q[i]) send_byte(text_q[i], eot_end && i == text_q.size() - 1, 0);
				sent += text_q.size();
			end
		end

		in_ch.valid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	// result side: random stalls, one long hold so the input backs up
	initial begin
		int   hold;
		tok_t want;
		result_cnt = 0;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = $urandom_range(0, 12);
			if ($urandom_range(0, 3) == 0) hold = 0;
			if (result_cnt == 60) hold = LONG_HOLD;
			if (hold > 0) begin
				res.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			result_cnt++;
			if (token_q.size() == 0) begin
				$error("unexpected result transaction char=%h", res.out_char);
				fail_cnt++;
				continue;
			end
			want = token_q.pop_front();
			if (res.out_char !== want.ch) begin
				$error("out_char expected %h actual %h", want.ch, res.out_char);
				fail_cnt++;
			end
			if (res.char_valid !== want.cv) begin
				$error("char_valid expected %b actual %b", want.cv, res.char_valid);
				fail_cnt++;
			end
			if (res.token_end !== want.te) begin
				$error("token_end expected %b actual %b", want.te, res.token_end);
				fail_cnt++;
			end
			if (res.word_truncated !== want.tr) begin
				$error("word_truncated expected %b actual %b", want.tr, res.word_truncated);
				fail_cnt++;
			end
			if (res.last !== want.last) begin
				$error("last expected %b actual %b", want.last, res.last);
				fail_cnt++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (res.valid && res.ready) ||
			(cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial idle_cycles = 0;
endmodule

// ----- affix_splitting_word_tokenizer_unit.f -----
+incdir+rtl
rtl/aswt_pkg.sv
rtl/aswt_if.sv
rtl/aswt_front.sv
rtl/aswt_cmdq.sv
rtl/aswt_emit.sv
rtl/affix_splitting_word_tokenizer_unit.sv
rtl/aswt_checker.sv
dv/tb_affix_splitting_word_tokenizer_unit.sv
